// ===== rtl/fbqg_pkg.sv =====
// Shared widths, thresholds, register indexes and action codes of the
// frame budget quality governor. No dependencies.
`default_nettype none

package fbqg_pkg;

  localparam int FBQG_WINDOW_LEN = 32;

  localparam int FT_W   = 16;
  localparam int TEMP_W = 11;
  localparam int PCT_W  = 7;
  localparam int ACT_W  = 3;
  localparam int RUN_W  = 6;
  localparam int IDX_W  = 2;
  localparam int CFG_W  = 16;

  localparam logic [IDX_W-1:0] REG_BUDGET    = 2'd0;
  localparam logic [IDX_W-1:0] REG_THERMAL   = 2'd1;
  localparam logic [IDX_W-1:0] REG_INIT_SCALE = 2'd2;
  localparam logic [IDX_W-1:0] REG_INIT_QUAL  = 2'd3;

  localparam logic [FT_W-1:0]  RST_BUDGET  = 16'd16667;
  localparam logic             RST_THERMAL = 1'b1;
  localparam logic [PCT_W-1:0] RST_SCALE   = 7'd50;
  localparam logic [PCT_W-1:0] RST_QUAL    = 7'd100;

  localparam logic [TEMP_W-1:0] TEMP_HOT  = 11'd750;
  localparam logic [TEMP_W-1:0] TEMP_CRIT = 11'd850;

  localparam logic [RUN_W-1:0] RUN_MAX    = 6'd63;
  localparam logic [RUN_W-1:0] RUN_THROT  = 6'd3;
  localparam logic [RUN_W-1:0] RUN_BUDGET = 6'd5;
  localparam logic [RUN_W-1:0] RUN_UP     = 6'd30;

  localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
  localparam logic [PCT_W-1:0] SCALE_MIN  = 7'd25;
  localparam logic [PCT_W-1:0] SCALE_MAX  = 7'd75;
  localparam logic [PCT_W-1:0] QUAL_MAX   = 7'd100;
  localparam logic [PCT_W-1:0] SCALE_DOWN = 7'd10;
  localparam logic [PCT_W-1:0] QUAL_DOWN  = 7'd15;
  localparam logic [PCT_W-1:0] PCT_UP     = 7'd5;

  localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CRIT   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_THROT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_BUDGET = 3'd3;
  localparam logic [ACT_W-1:0] ACT_UP     = 3'd4;

  typedef struct packed {
    logic             frame_ok;
    logic [PCT_W-1:0] scale_pct;
    logic [PCT_W-1:0] quality_pct;
    logic             throttled;
    logic [ACT_W-1:0] action;
  } fbqg_result_t;

endpackage

`default_nettype wire

// ===== rtl/fbqg_if.sv =====
// Valid/ready channel interfaces for frame beats and result beats.
// Depends on fbqg_pkg for field widths.
`default_nettype none

interface fbqg_in_if;
  import fbqg_pkg::*;
  logic              valid;
  logic              ready;
  logic [FT_W-1:0]   frame_time_us;
  logic [TEMP_W-1:0] temp_decideg;

  modport source (output valid, output frame_time_us, output temp_decideg, input ready);
  modport sink   (input valid, input frame_time_us, input temp_decideg, output ready);
endinterface

interface fbqg_out_if;
  import fbqg_pkg::*;
  logic             valid;
  logic             ready;
  logic             frame_ok;
  logic [PCT_W-1:0] scale_pct;
  logic [PCT_W-1:0] quality_pct;
  logic             throttled;
  logic [ACT_W-1:0] action;

  modport source (output valid, output frame_ok, output scale_pct, output quality_pct,
                  output throttled, output action, input ready);
  modport sink   (input valid, input frame_ok, input scale_pct, input quality_pct,
                  input throttled, input action, output ready);
endinterface

`default_nettype wire

// ===== rtl/fbqg_cell.sv =====
// One cell of the frame time window: holds one sample and passes it on
// to its neighbour on every shift. Depends on fbqg_pkg.
`default_nettype none

module fbqg_cell (
  input  logic                     clk,
  input  logic                     shift,
  input  logic [fbqg_pkg::FT_W-1:0] d,
  output logic [fbqg_pkg::FT_W-1:0] q
);
  import fbqg_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fbqg_window.sv =====
// Frame time window: a chain of fbqg_cell with running sum, fill count and
// budget-times-fill product; flags a low window average. Depends on fbqg_pkg.
`default_nettype none

module fbqg_window #(
  parameter int WINDOW_LEN = fbqg_pkg::FBQG_WINDOW_LEN
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic [fbqg_pkg::FT_W-1:0] frame_time,
  input  logic [fbqg_pkg::FT_W-1:0] budget,
  input  logic                      budget_we,
  input  logic [fbqg_pkg::FT_W-1:0] budget_data,
  output logic                      avg_low
);
  import fbqg_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = FT_W + FILL_W;
  localparam int BF_W   = FT_W + FILL_W;
  localparam int CMP_W  = SUM_W + 4;

  logic [FT_W-1:0]   taps [WINDOW_LEN+1];
  logic [SUM_W-1:0]  sum, sum_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [BF_W-1:0]   bf, bf_next;
  logic              full;
  logic [CMP_W-1:0]  sum_x10, bf_x7;

  assign taps[0] = frame_time;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    fbqg_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (taps[i]),
      .q     (taps[i+1])
    );
  end

  always_comb begin
    full      = (fill == FILL_W'(WINDOW_LEN));
    sum_next  = SUM_W'(sum + SUM_W'(frame_time) - (full ? SUM_W'(taps[WINDOW_LEN]) : '0));
    fill_next = full ? fill : FILL_W'(fill + 1'b1);
    bf_next   = full ? bf : BF_W'(bf + BF_W'(budget));
    sum_x10   = (CMP_W'(sum_next) << 3) + (CMP_W'(sum_next) << 1);
    bf_x7     = (CMP_W'(bf_next) << 3) - CMP_W'(bf_next);
    avg_low   = (sum_x10 < bf_x7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      fill <= '0;
      bf   <= '0;
    end else if (budget_we) begin
      bf <= BF_W'(BF_W'(budget_data) * BF_W'(fill));
    end else if (shift) begin
      sum  <= sum_next;
      fill <= fill_next;
      bf   <= bf_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WINDOW_LEN))
    else $error("window fill beyond window length");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    fill == '0 |-> sum == '0 && bf == '0)
    else $error("empty window with non-zero sum or product");

endmodule

`default_nettype wire

// ===== rtl/fbqg_skid.sv =====
// Two-entry result buffer: output register plus skid register, so a new
// frame is taken while a result waits. Depends on fbqg_pkg and fbqg_out_if.
`default_nettype none

module fbqg_skid (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  fbqg_pkg::fbqg_result_t res,
  output logic                   ready,
  fbqg_out_if.source             result
);
  import fbqg_pkg::*;

  fbqg_result_t head, spare;
  logic         head_valid, spare_valid;
  logic         pop;

  assign pop   = head_valid && result.ready;
  assign ready = !spare_valid;

  assign result.valid       = head_valid;
  assign result.frame_ok    = head.frame_ok;
  assign result.scale_pct   = head.scale_pct;
  assign result.quality_pct = head.quality_pct;
  assign result.throttled   = head.throttled;
  assign result.action      = head.action;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (push) begin
      if (!head_valid || pop) begin
        head       <= res;
        head_valid <= 1'b1;
      end else begin
        spare       <= res;
        spare_valid <= 1'b1;
      end
    end else if (pop) begin
      if (spare_valid) begin
        head        <= spare;
        spare_valid <= 1'b0;
      end else begin
        head_valid <= 1'b0;
      end
    end
  end

  a_spare_behind_head: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> head_valid)
    else $error("skid entry held without output entry");

endmodule

`default_nettype wire

// ===== rtl/frame_budget_quality_governor_unit.sv =====
// Frame budget quality governor, top level: run counters, scale/quality
// decision, configuration registers. Depends on fbqg_pkg, fbqg_if,
// fbqg_window, fbqg_skid.
//
// Use: one beat on the frame channel per finished frame (frame time in us,
// GPU temperature in tenths of a degree). Each accepted beat yields exactly
// one beat on the result channel: frame_ok, scale_pct, quality_pct,
// throttled and action. The user must write registers through cfg_we/
// cfg_index/cfg_data only while no frame is in flight; the block does not
// enforce it. A write to the initial scale or quality register also loads
// the current value, clamped to 100. The result is registered: it goes into
// the output register if that is free or being read, else into the skid
// entry. Throughput is one frame per cycle while frame.ready is high.
// Reset (rst, synchronous) empties the window, clears the run counters and
// the hot flag, and loads budget 16667, thermal checks on, scale 50 and
// quality 100; no clearing pass is needed, frames are taken at once.
// When the receiver stalls, a second result is held in a skid entry and
// frame.ready drops only while both entries are full.
`default_nettype none

module frame_budget_quality_governor_unit #(
  parameter int WINDOW_LEN = fbqg_pkg::FBQG_WINDOW_LEN
) (
  input  logic                        clk,
  input  logic                        rst,
  fbqg_in_if.sink                     frame,
  fbqg_out_if.source                  result,
  input  logic                        cfg_we,
  input  logic [fbqg_pkg::IDX_W-1:0]  cfg_index,
  input  logic [fbqg_pkg::CFG_W-1:0]  cfg_data
);
  import fbqg_pkg::*;

  logic [FT_W-1:0]  budget;
  logic             thermal_en;
  logic [RUN_W-1:0] over_run, under_run;
  logic [PCT_W-1:0] scale_now, quality_now;
  logic             hot_flag;

  logic [RUN_W-1:0] over_run_next, under_run_next;
  logic [PCT_W-1:0] scale_next, quality_next;
  logic             hot_flag_next;
  logic [PCT_W-1:0] down_scale, down_qual, up_scale, up_qual, cfg_pct;
  logic             over, crit, avg_low, push, buf_ready, budget_we;
  fbqg_result_t     res;

  assign push      = frame.valid && frame.ready;
  assign frame.ready = buf_ready;
  assign budget_we = cfg_we && (cfg_index == REG_BUDGET);
  assign cfg_pct   = (cfg_data[PCT_W-1:0] > PCT_FULL) ? PCT_FULL : cfg_data[PCT_W-1:0];

  fbqg_window #(.WINDOW_LEN(WINDOW_LEN)) u_window (
    .clk         (clk),
    .rst         (rst),
    .shift       (push),
    .frame_time  (frame.frame_time_us),
    .budget      (budget),
    .budget_we   (budget_we),
    .budget_data (cfg_data[FT_W-1:0]),
    .avg_low     (avg_low)
  );

  always_comb begin
    over = (frame.frame_time_us > budget);
    if (over) begin
      over_run_next  = (over_run < RUN_MAX) ? RUN_W'(over_run + 1'b1) : over_run;
      under_run_next = '0;
    end else begin
      over_run_next  = '0;
      under_run_next = (under_run < RUN_MAX) ? RUN_W'(under_run + 1'b1) : under_run;
    end
    hot_flag_next = thermal_en ? (frame.temp_decideg > TEMP_HOT) : hot_flag;
    crit          = thermal_en && (frame.temp_decideg > TEMP_CRIT);

    down_scale = (scale_now >= PCT_W'(SCALE_MIN + SCALE_DOWN)) ?
                 PCT_W'(scale_now - SCALE_DOWN) : SCALE_MIN;
    down_qual  = (quality_now >= QUAL_DOWN) ? PCT_W'(quality_now - QUAL_DOWN) : '0;
    up_scale   = ({1'b0, scale_now} + {1'b0, PCT_UP} > {1'b0, SCALE_MAX}) ?
                 SCALE_MAX : PCT_W'(scale_now + PCT_UP);
    up_qual    = ({1'b0, quality_now} + {1'b0, PCT_UP} > {1'b0, QUAL_MAX}) ?
                 QUAL_MAX : PCT_W'(quality_now + PCT_UP);

    scale_next   = scale_now;
    quality_next = quality_now;
    res.frame_ok = !over;
    res.action   = ACT_NONE;

    if (crit) begin
      scale_next   = SCALE_MIN;
      quality_next = '0;
      res.frame_ok = 1'b0;
      res.action   = ACT_CRIT;
    end else if (thermal_en && hot_flag_next && over_run_next >= RUN_THROT) begin
      scale_next     = down_scale;
      quality_next   = down_qual;
      over_run_next  = '0;
      under_run_next = '0;
      res.frame_ok   = 1'b0;
      res.action     = ACT_THROT;
    end else if (over_run_next >= RUN_BUDGET) begin
      scale_next     = down_scale;
      quality_next   = down_qual;
      over_run_next  = '0;
      under_run_next = '0;
      res.frame_ok   = 1'b0;
      res.action     = ACT_BUDGET;
    end else if (under_run_next >= RUN_UP && avg_low) begin
      scale_next     = up_scale;
      quality_next   = up_qual;
      over_run_next  = '0;
      under_run_next = '0;
      res.frame_ok   = 1'b1;
      res.action     = ACT_UP;
    end

    res.scale_pct   = scale_next;
    res.quality_pct = quality_next;
    res.throttled   = hot_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget      <= RST_BUDGET;
      thermal_en  <= RST_THERMAL;
      over_run    <= '0;
      under_run   <= '0;
      scale_now   <= RST_SCALE;
      quality_now <= RST_QUAL;
      hot_flag    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUDGET:     budget      <= cfg_data[FT_W-1:0];
        REG_THERMAL:    thermal_en  <= cfg_data[0];
        REG_INIT_SCALE: scale_now   <= cfg_pct;
        REG_INIT_QUAL:  quality_now <= cfg_pct;
        default: ;
      endcase
    end else if (push) begin
      over_run    <= over_run_next;
      under_run   <= under_run_next;
      scale_now   <= scale_next;
      quality_now <= quality_next;
      hot_flag    <= hot_flag_next;
    end
  end

  fbqg_skid u_skid (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .res    (res),
    .ready  (buf_ready),
    .result (result)
  );

  a_crit_forces_min: assert property (@(posedge clk) disable iff (rst)
    push && crit |=> scale_now == SCALE_MIN && quality_now == '0)
    else $error("critical temperature did not force minimum setting");

  a_step_clears_runs: assert property (@(posedge clk) disable iff (rst)
    push && !cfg_we && (res.action == ACT_THROT || res.action == ACT_BUDGET ||
                        res.action == ACT_UP)
    |=> over_run == '0 && under_run == '0)
    else $error("run counters not cleared after a step");

  a_runs_exclusive: assert property (@(posedge clk) disable iff (rst)
    over_run == '0 || under_run == '0)
    else $error("over and under runs both non-zero");

endmodule

`default_nettype wire
